### sv/gsac_pkg.sv
package gsac_pkg;

  localparam int SAMPLE_COUNT_DEF = 16;

  localparam int SAMPLE_W  = 12;
  localparam int PCT_W     = 14;
  localparam int ELAPSED_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [PCT_W-1:0]     PCT_FULL    = PCT_W'(10000);

  // (dry - avg) * 10000 needs 26 bits
  localparam int NUM_W = 26;

  // divider: quotient always fits DIV_QW bits, divisor DIV_VW bits
  localparam int DIV_QW = 14;
  localparam int DIV_VW = 13;
  localparam int DIV_DW = DIV_QW + DIV_VW;
  localparam int DIV_STEP_W = $clog2(DIV_QW + 1);

  typedef enum logic [1:0] {
    FN_START  = 2'd0,
    FN_TICK   = 2'd1,
    FN_SAMPLE = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_POWER = 3'd1,
    PH_CONV  = 3'd2,
    PH_READY = 3'd3,
    PH_ERROR = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GATE    = 3'd0,
    CFG_DELAY   = 3'd1,
    CFG_TIMEOUT = 3'd2,
    CFG_DRY     = 3'd3,
    CFG_WET     = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_AVG,
    SQ_SCALE,
    SQ_PSTART,
    SQ_PCT
  } seq_t;

  typedef struct packed {
    func_t                func;
    logic [SAMPLE_W-1:0]  sample;
  } in_t;

  typedef struct packed {
    phase_t               phase;
    logic                 supply_on;
    logic                 converter_enable;
    status_t              status;
    logic [PCT_W-1:0]     percent_x100;
    logic [SAMPLE_W-1:0]  raw_average;
  } out_t;

  typedef struct packed {
    logic               start;
    logic [DIV_DW-1:0]  dividend;
    logic [DIV_VW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_QW-1:0]  quotient;
  } div_rsp_t;

endpackage

### sv/gated_sensor_acquire_calibrate_top.sv
// Sensor acquisition sequencer: start, millisecond tick, converter sample and read commands
// arrive as input transfers, and every command returns one result transfer with the phase,
// supply and converter drives, the read status and the held average. The next command can
// be taken in the cycle its result is taken. The sample that completes the set of
// SAMPLE_COUNT samples has its result after a sequence of steps: the mean (a constant
// reciprocal multiply), the scale, the load of the restoring divider, the 14 divider steps
// and the hold of the answer. When the calibration is inverted or the mean sits at or beyond
// either level, the divider is skipped and the answer is held after the scale. Input ready
// stays low while the calculation runs. Configuration writes are accepted in any cycle.
module gated_sensor_acquire_calibrate_top #(
  parameter int SAMPLE_COUNT = gsac_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  gsac_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gsac_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gsac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsac_pkg::CFG_DAT_W-1:0]  cfg_data
);

  localparam int SUM_W = $clog2(SAMPLE_COUNT * 4095 + 1);
  localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);

  // mean by reciprocal multiply, exact floor for any sum of SUM_W bits
  localparam int AVG_SH = SUM_W + CNT_W;
  localparam int RCP_W  = AVG_SH + 1;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam logic [63:0]      AVG_ONE = 64'd1 << AVG_SH;
  localparam logic [RCP_W-1:0] AVG_RCP =
    RCP_W'((AVG_ONE + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

  // configuration
  logic        gate_r;
  logic [7:0]  delay_r;
  logic [15:0] tmo_r;
  logic [gsac_pkg::SAMPLE_W-1:0] dry_r, wet_r;

  // sequencer and measurement state
  gsac_pkg::seq_t    seq_r, seq_nxt;
  gsac_pkg::phase_t  phase_r, phase_nxt;
  gsac_pkg::status_t held_err_r, held_err_nxt;
  logic [gsac_pkg::ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [SUM_W-1:0]               sum_r, sum_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [gsac_pkg::PCT_W-1:0]     held_pct_r, held_pct_nxt;
  logic [gsac_pkg::SAMPLE_W-1:0]  held_avg_r;
  logic [gsac_pkg::NUM_W-1:0]     num_r;
  gsac_pkg::out_t                 out_r, out_nxt;
  logic                           out_valid_r;

  logic in_fire, out_fire, load_out, complete;
  gsac_pkg::status_t          status;
  logic [gsac_pkg::PCT_W-1:0] pct;
  logic [gsac_pkg::ELAPSED_W-1:0] el_inc, limit;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] cnt_inc;
  logic [PROD_W-1:0] avg_prod;

  // sequencer outputs
  gsac_pkg::div_req_t div_req;
  gsac_pkg::div_rsp_t div_rsp;
  logic ld_avg, ld_num, fin;
  logic [gsac_pkg::PCT_W-1:0] fin_pct;

  logic [gsac_pkg::SAMPLE_W-1:0] d_lvl, den;
  logic                          special;
  logic [gsac_pkg::PCT_W-1:0]    special_pct, q_pct;

  assign cfg_ready = 1'b1;
  assign in_ready  = (seq_r == gsac_pkg::SQ_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign avg_prod  = PROD_W'(sum_r) * PROD_W'(AVG_RCP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r  <= 1'b0;
      delay_r <= 8'd20;
      tmo_r   <= 16'd100;
      dry_r   <= 12'd4095;
      wet_r   <= 12'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gsac_pkg::CFG_GATE:    gate_r  <= cfg_data[0];
        gsac_pkg::CFG_DELAY:   delay_r <= cfg_data[7:0];
        gsac_pkg::CFG_TIMEOUT: tmo_r   <= cfg_data;
        gsac_pkg::CFG_DRY:     dry_r   <= cfg_data[gsac_pkg::SAMPLE_W-1:0];
        gsac_pkg::CFG_WET:     wet_r   <= cfg_data[gsac_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // calibration helpers, from the held average
  always_comb begin
    d_lvl       = dry_r - held_avg_r;
    den         = dry_r - wet_r;
    special     = (dry_r <= wet_r) || (held_avg_r >= dry_r) || (held_avg_r <= wet_r);
    special_pct = ((dry_r <= wet_r) || (held_avg_r >= dry_r)) ? '0 : gsac_pkg::PCT_FULL;
    q_pct       = (div_rsp.quotient > gsac_pkg::PCT_FULL) ? gsac_pkg::PCT_FULL
                                                          : div_rsp.quotient;
  end

  // command handling on an accepted input transfer
  always_comb begin
    phase_nxt    = phase_r;
    held_err_nxt = held_err_r;
    elapsed_nxt  = elapsed_r;
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    held_pct_nxt = held_pct_r;
    status       = gsac_pkg::ST_OK;
    pct          = '0;
    complete     = 1'b0;
    el_inc       = (elapsed_r == gsac_pkg::ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
    limit        = gsac_pkg::ELAPSED_W'(delay_r) + gsac_pkg::ELAPSED_W'(tmo_r);
    sum_add      = sum_r + SUM_W'(in_data.sample);
    cnt_inc      = cnt_r + 1'b1;
    if (in_fire) begin
      case (in_data.func)
        gsac_pkg::FN_START: begin
          if (phase_r != gsac_pkg::PH_POWER && phase_r != gsac_pkg::PH_CONV) begin
            elapsed_nxt = '0;
            sum_nxt     = '0;
            cnt_nxt     = '0;
            phase_nxt   = gate_r ? gsac_pkg::PH_POWER : gsac_pkg::PH_CONV;
          end
        end
        gsac_pkg::FN_TICK: begin
          elapsed_nxt = el_inc;
          if (phase_r == gsac_pkg::PH_POWER) begin
            if (el_inc >= gsac_pkg::ELAPSED_W'(delay_r)) phase_nxt = gsac_pkg::PH_CONV;
          end else if (phase_r == gsac_pkg::PH_CONV) begin
            if (el_inc > limit) begin
              held_err_nxt = gsac_pkg::ST_TIMEOUT;
              phase_nxt    = gsac_pkg::PH_ERROR;
            end
          end
        end
        gsac_pkg::FN_SAMPLE: begin
          if (phase_r == gsac_pkg::PH_CONV) begin
            sum_nxt  = sum_add;
            cnt_nxt  = cnt_inc;
            complete = (cnt_inc >= CNT_W'(SAMPLE_COUNT));
          end
        end
        gsac_pkg::FN_READ: begin
          if (phase_r == gsac_pkg::PH_READY) begin
            pct       = held_pct_r;
            phase_nxt = gsac_pkg::PH_IDLE;
          end else if (phase_r == gsac_pkg::PH_ERROR) begin
            status    = held_err_r;
            phase_nxt = gsac_pkg::PH_IDLE;
          end else begin
            status = gsac_pkg::ST_BUSY;
          end
        end
        default: ;
      endcase
    end
    // finish of the completing sample: answer is held, block goes to data ready
    if (fin) begin
      phase_nxt    = gsac_pkg::PH_READY;
      held_err_nxt = gsac_pkg::ST_OK;
      held_pct_nxt = fin_pct;
    end
    load_out = (in_fire && !complete) || fin;
    out_nxt.phase            = phase_nxt;
    out_nxt.supply_on        = gate_r && (phase_nxt == gsac_pkg::PH_POWER ||
                                          phase_nxt == gsac_pkg::PH_CONV);
    out_nxt.converter_enable = (phase_nxt == gsac_pkg::PH_CONV);
    out_nxt.status           = status;
    out_nxt.percent_x100     = pct;
    out_nxt.raw_average      = held_avg_r;
  end

  // sequencer: next state
  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      gsac_pkg::SQ_IDLE:   if (complete) seq_nxt = gsac_pkg::SQ_AVG;
      gsac_pkg::SQ_AVG:    seq_nxt = gsac_pkg::SQ_SCALE;
      gsac_pkg::SQ_SCALE:  seq_nxt = special ? gsac_pkg::SQ_IDLE : gsac_pkg::SQ_PSTART;
      gsac_pkg::SQ_PSTART: seq_nxt = gsac_pkg::SQ_PCT;
      gsac_pkg::SQ_PCT:    if (div_rsp.done) seq_nxt = gsac_pkg::SQ_IDLE;
      default:             seq_nxt = gsac_pkg::SQ_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    div_req.start    = 1'b0;
    // round half up: (2*num + den) / (2*den)
    div_req.dividend = {num_r, 1'b0} + gsac_pkg::DIV_DW'(den);
    div_req.divisor  = {den, 1'b0};
    ld_avg  = 1'b0;
    ld_num  = 1'b0;
    fin     = 1'b0;
    fin_pct = q_pct;
    case (seq_r)
      gsac_pkg::SQ_AVG:    ld_avg = 1'b1;
      gsac_pkg::SQ_SCALE: begin
        ld_num  = !special;
        fin     = special;
        fin_pct = special_pct;
      end
      gsac_pkg::SQ_PSTART: div_req.start = 1'b1;
      gsac_pkg::SQ_PCT:    fin = div_rsp.done;
      default: ;
    endcase
  end

  gsac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= gsac_pkg::SQ_IDLE;
      phase_r     <= gsac_pkg::PH_IDLE;
      held_err_r  <= gsac_pkg::ST_OK;
      elapsed_r   <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      held_pct_r  <= '0;
      held_avg_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r      <= seq_nxt;
      phase_r    <= phase_nxt;
      held_err_r <= held_err_nxt;
      elapsed_r  <= elapsed_nxt;
      sum_r      <= sum_nxt;
      cnt_r      <= cnt_nxt;
      held_pct_r <= held_pct_nxt;
      if (ld_avg) held_avg_r <= avg_prod[AVG_SH +: gsac_pkg::SAMPLE_W];
      if (load_out)      out_valid_r <= 1'b1;
      else if (out_fire) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_r <= out_nxt;
    if (ld_num)   num_r <= gsac_pkg::NUM_W'(d_lvl) * gsac_pkg::NUM_W'(14'd10000);
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (seq_r == gsac_pkg::SQ_PCT))
    else $error("divider finished outside a wait state");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SAMPLE_COUNT))
    else $error("sample counter beyond set size");

  a_pct_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_pct_r <= gsac_pkg::PCT_FULL)
    else $error("held percentage above full scale");

  a_busy_conv: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r != gsac_pkg::SQ_IDLE |-> phase_r == gsac_pkg::PH_CONV && !in_ready)
    else $error("calculation running outside converting phase");

  a_fin_ready: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> phase_r == gsac_pkg::PH_READY && out_valid_r)
    else $error("finished calculation did not present data ready");

endmodule

### sv/gsac_div.sv
module gsac_div (
  input  logic                clk,
  input  logic                rst_n,
  input  gsac_pkg::div_req_t  req,
  output gsac_pkg::div_rsp_t  rsp
);

  logic [gsac_pkg::DIV_VW-1:0]     rem_r, rem_nxt;
  logic [gsac_pkg::DIV_QW-1:0]     low_r, low_nxt;
  logic [gsac_pkg::DIV_VW-1:0]     dvs_r;
  logic [gsac_pkg::DIV_STEP_W-1:0] step_r;
  logic                            run_r;
  logic                            done_r;

  logic [gsac_pkg::DIV_VW:0]   shifted;
  logic [gsac_pkg::DIV_VW+1:0] diff;
  logic                        ge;

  // restoring step: dividend bits leave the top of low_r, quotient bits enter at the bottom
  always_comb begin
    shifted = {rem_r, low_r[gsac_pkg::DIV_QW-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    ge      = ~diff[gsac_pkg::DIV_VW+1];
    rem_nxt = ge ? diff[gsac_pkg::DIV_VW-1:0] : shifted[gsac_pkg::DIV_VW-1:0];
    low_nxt = {low_r[gsac_pkg::DIV_QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (req.start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      step_r <= gsac_pkg::DIV_STEP_W'(gsac_pkg::DIV_QW);
    end else if (run_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == gsac_pkg::DIV_STEP_W'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      // upper part is below the divisor since the quotient fits DIV_QW bits
      rem_r <= req.dividend[gsac_pkg::DIV_QW +: gsac_pkg::DIV_VW];
      low_r <= req.dividend[gsac_pkg::DIV_QW-1:0];
      dvs_r <= req.divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = low_r;

endmodule

### tb/gsac_result_checker.sv
module gsac_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  gsac_pkg::in_t                   in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  gsac_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [gsac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsac_pkg::CFG_DAT_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gsac_pkg::*;

  localparam int SET_SIZE = SAMPLE_COUNT_DEF;

  // register copy
  logic                gate_on;
  logic [7:0]          delay_ms;
  logic [15:0]         timeout_ms;
  logic [SAMPLE_W-1:0] dry_raw;
  logic [SAMPLE_W-1:0] wet_raw;

  // sequencer copy
  phase_t                phase_q;
  logic [ELAPSED_W-1:0]  elapsed;
  logic [15:0]           sample_sum;
  int                    sample_cnt;
  logic [PCT_W-1:0]      held_pct;
  logic [SAMPLE_W-1:0]   held_avg;
  status_t               held_err;

  out_t expected_reports[$];
  out_t want;

  function automatic logic [PCT_W-1:0] calibrate_hundredths(logic [SAMPLE_W-1:0] avg);
    int unsigned num;
    int unsigned den;
    int unsigned q;
    if (dry_raw <= wet_raw || avg >= dry_raw) return '0;
    if (avg <= wet_raw) return PCT_FULL;
    num = (int'(dry_raw) - int'(avg)) * 10000;
    den = int'(dry_raw) - int'(wet_raw);
    // round half up
    q = (2 * num + den) / (2 * den);
    if (q > 10000) q = 10000;
    return q[PCT_W-1:0];
  endfunction

  function automatic out_t step_sequencer(in_t cmd);
    out_t             res;
    status_t          st;
    logic [PCT_W-1:0] pct;
    st  = ST_OK;
    pct = '0;
    case (cmd.func)
      FN_START: begin
        if (phase_q != PH_POWER && phase_q != PH_CONV) begin
          elapsed    = '0;
          sample_sum = '0;
          sample_cnt = 0;
          phase_q    = gate_on ? PH_POWER : PH_CONV;
        end
      end
      FN_TICK: begin
        if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
        if (phase_q == PH_POWER) begin
          if (elapsed >= delay_ms) phase_q = PH_CONV;
        end else if (phase_q == PH_CONV &&
                     int'(elapsed) > int'(delay_ms) + int'(timeout_ms)) begin
          held_err = ST_TIMEOUT;
          phase_q  = PH_ERROR;
        end
      end
      FN_SAMPLE: begin
        if (phase_q == PH_CONV) begin
          sample_sum = sample_sum + cmd.sample;
          sample_cnt++;
          if (sample_cnt >= SET_SIZE) begin
            held_avg = SAMPLE_W'(sample_sum / SET_SIZE);
            held_pct = calibrate_hundredths(held_avg);
            held_err = ST_OK;
            phase_q  = PH_READY;
          end
        end
      end
      default: begin
        case (phase_q)
          PH_READY: begin
            pct     = held_pct;
            phase_q = PH_IDLE;
          end
          PH_ERROR: begin
            st      = held_err;
            phase_q = PH_IDLE;
          end
          default: st = ST_BUSY;
        endcase
      end
    endcase
    res.phase            = phase_q;
    res.supply_on        = gate_on && (phase_q == PH_POWER || phase_q == PH_CONV);
    res.converter_enable = (phase_q == PH_CONV);
    res.status           = st;
    res.percent_x100     = pct;
    res.raw_average      = held_avg;
    return res;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gate_on    = 1'b0;
      delay_ms   = 8'd20;
      timeout_ms = 16'd100;
      dry_raw    = 12'd4095;
      wet_raw    = 12'd0;
      phase_q    = PH_IDLE;
      elapsed    = '0;
      sample_sum = '0;
      sample_cnt = 0;
      held_pct   = '0;
      held_avg   = '0;
      held_err   = ST_OK;
      fail_count = 0;
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GATE:    gate_on    = cfg_data[0];
          CFG_DELAY:   delay_ms   = cfg_data[7:0];
          CFG_TIMEOUT: timeout_ms = cfg_data;
          CFG_DRY:     dry_raw    = cfg_data[SAMPLE_W-1:0];
          CFG_WET:     wet_raw    = cfg_data[SAMPLE_W-1:0];
          default: ;
        endcase
      end
      // take the command before the result: a result never belongs to the same edge
      if (in_valid && in_ready) expected_reports.push_back(step_sequencer(in_data));
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("phase", 16'(want.phase), 16'(out_data.phase));
          check_field("supply_on", 16'(want.supply_on), 16'(out_data.supply_on));
          check_field("converter_enable", 16'(want.converter_enable),
                      16'(out_data.converter_enable));
          check_field("status", 16'(want.status), 16'(out_data.status));
          check_field("percent_x100", 16'(want.percent_x100), 16'(out_data.percent_x100));
          check_field("raw_average", 16'(want.raw_average), 16'(out_data.raw_average));
        end
      end
    end
    pending = expected_reports.size();
  end

endmodule

### tb/tb_gated_sensor_acquire_calibrate_top.sv
module tb_gated_sensor_acquire_calibrate_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gsac_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_ITEMS   = 320;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int cycle_count   = 0;
  int commands_sent = 0;
  bit calm          = 1'b0;
  bit hold_req      = 1'b0;

  // stimulus view of the registers
  bit gate_set;
  int delay_set;
  int timeout_set;
  int dry_set;
  int wet_set;

  always #10 clk = ~clk;

  gated_sensor_acquire_calibrate_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gsac_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 18);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL gated_sensor_acquire_calibrate_top");
    $finish;
  end

  task automatic send_cmd(func_t f, logic [SAMPLE_W-1:0] s);
    if (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{func: f, sample: s};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    commands_sent++;
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic apply_settings(int p);
    logic [CFG_DAT_W-1:0] val;
    // drain before touching the registers
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    case (p)
      1: begin
        gate_set = 1; delay_set = 0; timeout_set = 0; dry_set = 4095; wet_set = 0;
      end
      2: begin
        gate_set = 0; delay_set = 255; timeout_set = 65535; dry_set = 3000; wet_set = 1000;
      end
      3: begin
        gate_set = 1; delay_set = $urandom_range(1, 6); timeout_set = $urandom_range(0, 30);
        dry_set = $urandom_range(4095); wet_set = $urandom_range(4095);
      end
      4: begin
        gate_set = 1; delay_set = 2; timeout_set = 40; dry_set = 0; wet_set = 4095;
      end
      5: begin
        gate_set = 0; delay_set = $urandom_range(10); timeout_set = $urandom_range(20);
        dry_set = $urandom_range(4095); wet_set = dry_set;
      end
      default: begin
        gate_set = 1; delay_set = $urandom_range(8); timeout_set = $urandom_range(60);
        dry_set = $urandom_range(2048, 4095); wet_set = $urandom_range(2047);
      end
    endcase
    // fill unused upper bits with noise, the block must mask them
    val = 16'($urandom); val[0] = gate_set;
    write_register(CFG_GATE, val);
    val = 16'($urandom); val[7:0] = 8'(delay_set);
    write_register(CFG_DELAY, val);
    write_register(CFG_TIMEOUT, 16'(timeout_set));
    val = 16'($urandom); val[11:0] = 12'(dry_set);
    write_register(CFG_DRY, val);
    val = 16'($urandom); val[11:0] = 12'(wet_set);
    write_register(CFG_WET, val);
    if (p == 1) write_register(CFG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_measurement();
    int mode;
    int lo;
    int hi;
    int centre;
    int ticks_used;
    int got;
    int r;
    logic [SAMPLE_W-1:0] s;
    mode = $urandom_range(3);
    lo   = (dry_set < wet_set) ? dry_set : wet_set;
    hi   = (dry_set < wet_set) ? wet_set : dry_set;
    case ($urandom_range(3))
      0: centre = 0;
      1: centre = 4095;
      2: centre = dry_set;
      default: centre = wet_set;
    endcase
    if (mode == 3) centre = $urandom_range(4095);
    send_cmd(FN_START, 12'($urandom));
    ticks_used = 0;
    if (gate_set) begin
      // a zero delay still needs one tick to leave power-up
      ticks_used = (delay_set == 0) ? 1 : delay_set;
      repeat (ticks_used) send_cmd(FN_TICK, 12'($urandom));
    end
    got = 0;
    while (got < SAMPLE_COUNT_DEF) begin
      r = $urandom_range(99);
      if (r < 8 && ticks_used < delay_set + timeout_set) begin
        send_cmd(FN_TICK, 12'($urandom));
        ticks_used++;
      end else if (r < 11) begin
        send_cmd(FN_READ, 12'($urandom));
      end else if (r < 13) begin
        send_cmd(FN_START, 12'($urandom));
      end else begin
        case (mode)
          0: s = 12'($urandom);
          1: s = 12'(centre);
          2: s = 12'($urandom_range(hi, lo));
          default: begin
            r = centre + $urandom_range(48) - 24;
            s = (r < 0) ? 12'd0 : (r > 4095) ? 12'd4095 : 12'(r);
          end
        endcase
        send_cmd(FN_SAMPLE, s);
        got++;
      end
    end
    if ($urandom_range(9) == 0) send_cmd($urandom_range(1) ? FN_TICK : FN_SAMPLE, 12'($urandom));
    r = $urandom_range(99);
    if (r < 90) send_cmd(FN_READ, 12'($urandom));
    if (r >= 80 && r < 90) send_cmd(FN_READ, 12'($urandom));
  endtask

  task automatic run_timeout();
    int total;
    int sent;
    int samples;
    total   = delay_set + timeout_set + 1 + ((gate_set && delay_set + timeout_set == 0) ? 1 : 0);
    sent    = 0;
    samples = 0;
    send_cmd(FN_START, 12'($urandom));
    while (sent < total) begin
      // never complete the set
      if ($urandom_range(3) == 0 && samples < SAMPLE_COUNT_DEF - 1) begin
        send_cmd(FN_SAMPLE, 12'($urandom));
        samples++;
      end else begin
        send_cmd(FN_TICK, 12'($urandom));
        sent++;
      end
    end
    if ($urandom_range(3) == 0) send_cmd(FN_TICK, 12'($urandom));
    if ($urandom_range(9) < 8) send_cmd(FN_READ, 12'($urandom));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 6)) send_cmd(func_t'($urandom_range(3)), 12'($urandom));
  endtask

  initial begin
    int p;
    int phase_base;
    int r;
    bit hold_done;
    hold_done = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    gate_set = 0; delay_set = 20; timeout_set = 100; dry_set = 4095; wet_set = 0;

    // directed pass on reset settings
    send_cmd(FN_READ, 12'hFFF);
    send_cmd(FN_TICK, 12'h000);
    send_cmd(FN_SAMPLE, 12'hABC);
    send_cmd(FN_START, 12'h555);
    send_cmd(FN_START, 12'hAAA);
    send_cmd(FN_READ, 12'h000);
    repeat (8) send_cmd(FN_SAMPLE, 12'hFFF);
    repeat (8) send_cmd(FN_SAMPLE, 12'h000);
    send_cmd(FN_SAMPLE, 12'h123);
    send_cmd(FN_READ, 12'h000);
    send_cmd(FN_READ, 12'h000);

    for (p = 1; p <= 6; p++) begin
      apply_settings(p);
      phase_base = commands_sent;
      while (commands_sent - phase_base < PHASE_ITEMS) begin
        calm = (p == 3) && (commands_sent - phase_base < 250);
        if (p == 2 && !hold_done && commands_sent - phase_base > 100) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 70) run_measurement();
        else if (r < 85 && delay_set + timeout_set <= 90) run_timeout();
        else run_noise();
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS gated_sensor_acquire_calibrate_top");
    end else begin
      $display("FAIL gated_sensor_acquire_calibrate_top");
    end
    $finish;
  end

endmodule

### sim.f
sv/gsac_pkg.sv
sv/gsac_div.sv
sv/gated_sensor_acquire_calibrate_top.sv
tb/gsac_result_checker.sv
tb/tb_gated_sensor_acquire_calibrate_top.sv
